[hdl/fbc_pkg.sv]
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types and constants of the frame builder: the input item and output
// word layouts, item codes, header size and the ones'-complement byte add.
// ----------------------------------------------------------------------------
package fbc_pkg;

  // Field widths.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned LEN_W  = 11;

  // Largest payload length; longer requests are clipped to it.
  localparam int unsigned MAX_PAYLOAD = 1024;

  // Header is the start mark, four sequence bytes and four length bytes.
  localparam int unsigned HDR_BYTES = 9;
  localparam int unsigned HDR_W     = HDR_BYTES * BYTE_W;
  localparam int unsigned CNT_W     = $clog2(HDR_BYTES + 1);

  // Reset value of the start mark register.
  localparam logic [BYTE_W-1:0] START_MARK_RESET = 8'h01;

  // Item codes carried in the func field.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_DATA  = 1'b1;

  // One input item.
  typedef struct packed {
    logic             func;
    logic [SEQ_W-1:0] seq_num;
    logic [LEN_W-1:0] payload_length;
    logic [BYTE_W-1:0] payload_byte;
  } item_t;

  // One output word.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              frame_end;
  } word_t;

  // 8-bit ones'-complement add with end-around carry.
  function automatic logic [BYTE_W-1:0] oc_add(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, s[BYTE_W]};
  endfunction

endpackage

[hdl/frame_builder_checksum.sv]
// ----------------------------------------------------------------------------
// frame_builder_checksum
// Serializes link frames: header bytes, payload bytes and a closing
// ones'-complement checksum byte, one output word per cycle while word_stall is low.
// ----------------------------------------------------------------------------
// A payload item is taken every cycle unless word_stall holds the output, and
// leaves as one word through the byte queue and the output register; the last
// payload byte of a frame is followed by the checksum word. A start item keeps
// the block busy until its nine header bytes (and the checksum word, when the
// payload length is zero) have left, a byte at a time. A one-stage byte queue
// feeds the output register, so an item is taken while a finished word still
// waits at the output; item_stall follows word_stall combinationally.
// Payload lengths above 1024 are clipped to 1024 in the header and the count.
// A start item abandons any open frame without a checksum; a payload item with
// no open frame is taken and dropped.
module frame_builder_checksum (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        mark_wr_en,
  input  logic [fbc_pkg::BYTE_W-1:0]  mark_wr_data,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  fbc_pkg::item_t              item,
  output logic                        word_valid,
  input  logic                        word_stall,
  output fbc_pkg::word_t              word
);
  import fbc_pkg::*;

  // Configuration and frame state.
  logic [BYTE_W-1:0] start_mark;
  logic [BYTE_W-1:0] running_sum;
  logic [BYTE_W-1:0] running_sum_next;
  logic [LEN_W-1:0]  bytes_left;
  logic              frame_open;

  // Byte queue between the input and the output register.
  logic [HDR_W-1:0]  q_data;
  logic [CNT_W-1:0]  q_cnt;
  logic              q_check;

  // Handshake terms.
  logic              busy;
  logic              out_free;
  logic              emit;
  logic              emit_check;
  logic              last_emit;
  logic              accept;

  // Decoded input item.
  logic [LEN_W-1:0]  len_sat;
  logic [LEN_W-1:0]  left_dec;
  logic [HDR_W-1:0]  hdr_bytes;

  // Queue occupancy and output handshake.
  assign busy       = (q_cnt != '0) || q_check;
  assign out_free   = !word_valid || !word_stall;
  assign emit       = busy && out_free;
  assign emit_check = emit && (q_cnt == '0);
  assign last_emit  = emit && (((q_cnt == CNT_W'(1)) && !q_check) || emit_check);
  assign item_stall = busy && !last_emit;
  assign accept     = item_valid && !item_stall;

  // Length clipping and payload countdown.
  always_comb begin
    if (32'(item.payload_length) > 32'(MAX_PAYLOAD)) begin
      len_sat = LEN_W'(MAX_PAYLOAD);
    end else begin
      len_sat = item.payload_length;
    end
    if (bytes_left != '0) begin
      left_dec = bytes_left - LEN_W'(1);
    end else begin
      left_dec = '0;
    end
    hdr_bytes = {start_mark, item.seq_num, 32'(len_sat)};
  end

  // Running sum: updated on every header and payload word, cleared by checksum and start.
  always_comb begin
    running_sum_next = running_sum;
    if (emit) begin
      if (emit_check) begin
        running_sum_next = '0;
      end else begin
        running_sum_next = oc_add(running_sum, q_data[HDR_W-1 -: BYTE_W]);
      end
    end
    if (accept && (item.func == FUNC_START)) begin
      running_sum_next = '0;
    end
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_mark  <= START_MARK_RESET;
      running_sum <= '0;
      bytes_left  <= '0;
      frame_open  <= 1'b0;
      q_cnt       <= '0;
      q_check     <= 1'b0;
      word_valid  <= 1'b0;
    end else begin
      if (mark_wr_en) begin
        start_mark <= mark_wr_data;
      end
      running_sum <= running_sum_next;

      // Output register.
      if (emit) begin
        word_valid <= 1'b1;
        if (emit_check) begin
          word.out_byte  <= ~running_sum;
          word.frame_end <= 1'b1;
        end else begin
          word.out_byte  <= q_data[HDR_W-1 -: BYTE_W];
          word.frame_end <= 1'b0;
        end
      end else if (!word_stall) begin
        word_valid <= 1'b0;
      end

      // Queue drains one byte per emitted header or payload word.
      if (emit) begin
        if (emit_check) begin
          q_check <= 1'b0;
        end else begin
          q_cnt  <= q_cnt - CNT_W'(1);
          q_data <= q_data << BYTE_W;
        end
      end

      // A start item, or a payload item of an open frame, loads the queue and frame state.
      if (accept) begin
        if (item.func == FUNC_START) begin
          q_data  <= hdr_bytes;
          q_cnt   <= CNT_W'(HDR_BYTES);
          q_check <= (len_sat == '0);
          bytes_left <= len_sat;
          frame_open <= (len_sat != '0);
        end else if (frame_open) begin
          q_data  <= {item.payload_byte, {(HDR_W-BYTE_W){1'b0}}};
          q_cnt   <= CNT_W'(1);
          q_check <= (left_dec == '0);
          bytes_left <= left_dec;
          frame_open <= (left_dec != '0);
        end
      end
    end
  end

  // An open frame always expects more payload.
  a_open_has_bytes: assert property (@(posedge clk) disable iff (rst)
    frame_open |-> (bytes_left != '0))
    else $error("open frame with no payload left");

  // A start item fills the queue with the whole header.
  a_start_loads_hdr: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.func == FUNC_START)) |=> (q_cnt == CNT_W'(HDR_BYTES)))
    else $error("start item did not load the header");

  // The checksum word clears the running sum.
  a_check_clears_sum: assert property (@(posedge clk) disable iff (rst)
    emit_check |=> (running_sum == '0))
    else $error("running sum not cleared after checksum");

  // The byte queue never holds more than one header.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= CNT_W'(HDR_BYTES))
    else $error("byte queue overfilled");

endmodule
